// ----- design/dtfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time field editor package
// Shared types, constants and calendar helpers for the field editor.
// ----------------------------------------------------------------------------
package dtfe_pkg;

	typedef enum logic [1:0] {
		ACT_NEXT_FIELD = 2'd0,
		ACT_INCREMENT  = 2'd1,
		ACT_DECREMENT  = 2'd2,
		ACT_LOAD       = 2'd3
	} dtfe_action_t;

	typedef enum logic [2:0] {
		FLD_YEAR   = 3'd0,
		FLD_MONTH  = 3'd1,
		FLD_DAY    = 3'd2,
		FLD_HOUR   = 3'd3,
		FLD_MINUTE = 3'd4,
		FLD_SECOND = 3'd5
	} dtfe_field_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} dtfe_time_t;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned OUT_USER_W = 1;

	localparam logic [2:0] NUM_FIELDS = 3'd6;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [6:0] MONTH_MIN  = 7'd1;
	localparam logic [6:0] MONTH_MAX  = 7'd12;
	localparam logic [6:0] DAY_MIN    = 7'd1;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;
	localparam logic [6:0] ZERO_VAL   = 7'd0;

	localparam dtfe_time_t TIME_RESET = '{
		year:   7'd26,
		month:  4'd7,
		day:    5'd5,
		hour:   5'd23,
		minute: 6'd59,
		second: 6'd55
	};

	function automatic logic [4:0] days_in_month(input logic [3:0] month,
		input logic [6:0] year);
		logic [4:0] len;
		case (month)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
		input logic [6:0] hi);
		return (v >= hi || v < lo) ? lo : v + 7'd1;
	endfunction

	function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
		input logic [6:0] hi);
		return (v <= lo || v > hi) ? hi : v - 7'd1;
	endfunction

endpackage

// ----- design/dtfe_next.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time field editor next-state logic
// Applies one key action to the held date, time and selection.
// ----------------------------------------------------------------------------
module dtfe_next (
	input  dtfe_pkg::dtfe_action_t action,
	input  dtfe_pkg::dtfe_time_t   cur_time,
	input  logic [2:0]             cur_sel,
	input  dtfe_pkg::dtfe_time_t   load_time,
	output dtfe_pkg::dtfe_time_t   nxt_time,
	output logic [2:0]             nxt_sel,
	output logic                   rejected
);
	import dtfe_pkg::*;

	dtfe_time_t edit_time;
	logic       up;
	logic [6:0] len;
	logic [6:0] v;
	logic [6:0] r;
	logic       load_ok;

	always_comb begin
		up  = (action == ACT_INCREMENT);
		len = {2'b00, days_in_month(cur_time.month, cur_time.year)};
		edit_time = cur_time;
		case (cur_sel)
			FLD_YEAR: begin
				v = cur_time.year;
				r = up ? wrap_up(v, ZERO_VAL, YEAR_MAX) : wrap_down(v, ZERO_VAL, YEAR_MAX);
				edit_time.year = r;
			end
			FLD_MONTH: begin
				v = {3'b000, cur_time.month};
				r = up ? wrap_up(v, MONTH_MIN, MONTH_MAX) : wrap_down(v, MONTH_MIN, MONTH_MAX);
				edit_time.month = r[3:0];
			end
			FLD_DAY: begin
				v = {2'b00, cur_time.day};
				r = up ? wrap_up(v, DAY_MIN, len) : wrap_down(v, DAY_MIN, len);
				edit_time.day = r[4:0];
			end
			FLD_HOUR: begin
				v = {2'b00, cur_time.hour};
				r = up ? wrap_up(v, ZERO_VAL, HOUR_MAX) : wrap_down(v, ZERO_VAL, HOUR_MAX);
				edit_time.hour = r[4:0];
			end
			FLD_MINUTE: begin
				v = {1'b0, cur_time.minute};
				r = up ? wrap_up(v, ZERO_VAL, MINSEC_MAX) : wrap_down(v, ZERO_VAL, MINSEC_MAX);
				edit_time.minute = r[5:0];
			end
			FLD_SECOND: begin
				v = {1'b0, cur_time.second};
				r = up ? wrap_up(v, ZERO_VAL, MINSEC_MAX) : wrap_down(v, ZERO_VAL, MINSEC_MAX);
				edit_time.second = r[5:0];
			end
			default: begin
				v = ZERO_VAL;
				r = ZERO_VAL;
			end
		endcase
		// A month or year change can leave the day past the end of the month.
		if (edit_time.day > days_in_month(edit_time.month, edit_time.year)) begin
			edit_time.day = 5'd1;
		end
	end

	always_comb begin
		load_ok = ({1'b0, load_time.year} <= {1'b0, YEAR_MAX})
			&& ({3'b000, load_time.month} >= MONTH_MIN)
			&& ({3'b000, load_time.month} <= MONTH_MAX)
			&& ({2'b00, load_time.day} >= DAY_MIN)
			&& (load_time.day <= days_in_month(load_time.month, load_time.year))
			&& ({2'b00, load_time.hour} <= HOUR_MAX)
			&& ({1'b0, load_time.minute} <= MINSEC_MAX)
			&& ({1'b0, load_time.second} <= MINSEC_MAX);
	end

	always_comb begin
		nxt_time = cur_time;
		nxt_sel  = cur_sel;
		rejected = 1'b0;
		case (action)
			ACT_NEXT_FIELD: begin
				nxt_sel = (cur_sel + 3'd1 >= NUM_FIELDS || cur_sel == 3'd7) ? 3'd0
					: cur_sel + 3'd1;
			end
			ACT_INCREMENT, ACT_DECREMENT: begin
				nxt_time = edit_time;
			end
			ACT_LOAD: begin
				if (load_ok) begin
					nxt_time = load_time;
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
				nxt_time = cur_time;
			end
		endcase
	end

endmodule

// ----- design/date_time_field_editor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time field editor
// Setting-screen editor for a two-digit year, month, day, hour, minute and
// second with a selected-field index, driven by one key action per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one key action and is answered by exactly one
// output beat showing all six fields, the selection and a load-rejected
// flag. The block takes one beat per clock cycle unless the output side
// stalls; an accepted key lands in the input register, and its result beat
// is offered on the output from the result register, which loads together
// with the field registers. Stalls on the output side hold both stages and
// the field registers in place.
module date_time_field_editor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// load_year[6:0], load_month[10:7], load_day[15:11], load_hour[20:16],
	// load_minute[26:21], load_second[32:27], zero fill [39:33]
	input  logic [dtfe_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [dtfe_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// year_out[6:0], month_out[10:7], day_out[15:11], hour_out[20:16],
	// minute_out[26:21], second_out[32:27], selected_out[35:33], zero fill [39:36]
	output logic [dtfe_pkg::OUT_DATA_W-1:0] m_tdata,
	// load_rejected[0]
	output logic [dtfe_pkg::OUT_USER_W-1:0] m_tuser
);
	import dtfe_pkg::*;

	logic         valid_s1;
	dtfe_action_t action_s1;
	dtfe_time_t   load_s1;
	logic         valid_s2;
	logic [35:0]  data_s2;
	logic         rej_s2;
	dtfe_time_t   time_q;
	logic [2:0]   sel_q;
	dtfe_time_t   nxt_time;
	logic [2:0]   nxt_sel;
	logic         nxt_rej;
	logic         advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1     <= dtfe_action_t'(s_tuser[1:0]);
			load_s1.year   <= s_tdata[6:0];
			load_s1.month  <= s_tdata[10:7];
			load_s1.day    <= s_tdata[15:11];
			load_s1.hour   <= s_tdata[20:16];
			load_s1.minute <= s_tdata[26:21];
			load_s1.second <= s_tdata[32:27];
		end
	end

	dtfe_next u_next (
		.action    (action_s1),
		.cur_time  (time_q),
		.cur_sel   (sel_q),
		.load_time (load_s1),
		.nxt_time  (nxt_time),
		.nxt_sel   (nxt_sel),
		.rejected  (nxt_rej)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= TIME_RESET;
			sel_q    <= 3'd0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				time_q <= nxt_time;
				sel_q  <= nxt_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2 <= {nxt_sel, nxt_time.second, nxt_time.minute, nxt_time.hour,
				nxt_time.day, nxt_time.month, nxt_time.year};
			rej_s2  <= nxt_rej;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W - 36){1'b0}}, data_s2};
	assign m_tuser  = rej_s2;

endmodule
